### hdl/bsp_pc_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pc_pkg - shared types and constants of the bsp point contents block
// field widths, command codes, register map, datapath op codes and
// the control and status structs between controller and datapath
// ----------------------------------------------------------------------------
`default_nettype none

package bsp_pc_pkg;

    // default table sizes
    localparam int NODE_COUNT_DEF  = 1024;
    localparam int PLANE_COUNT_DEF = 1024;

    // field widths
    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 10;
    localparam int VEC_W      = 32;
    localparam int KIND_W     = 3;
    localparam int REF_W      = 10;
    localparam int CHILD_W    = 11;
    localparam int CODE_W     = 5;
    localparam int STEPS_W    = 11;
    localparam int PROD_W     = 2 * VEC_W;
    localparam int ACC_W      = PROD_W + 2;

    // stream payload widths
    localparam int S_TDATA_W  = 176;
    localparam int S_TUSER_W  = CMD_W;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NODE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PLANE = 2'd2;

    // plane kinds below this one are axial
    localparam logic [KIND_W-1:0] KIND_GENERAL = 3'd3;
    localparam logic [KIND_W-1:0] KIND_AXIS_X  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_AXIS_Y  = 3'd1;

    // node word: plane ref, front child, back child
    localparam int NODE_W      = 32;
    localparam int NODE_REF_LO = 0;
    localparam int NODE_FR_LO  = REF_W;
    localparam int NODE_BK_LO  = REF_W + CHILD_W;

    // plane word: nx, ny, nz, offset, kind
    localparam int PLANE_W     = 4 * VEC_W + KIND_W;
    localparam int PL_NX_LO    = 0;
    localparam int PL_NY_LO    = VEC_W;
    localparam int PL_NZ_LO    = 2 * VEC_W;
    localparam int PL_OFF_LO   = 3 * VEC_W;
    localparam int PL_KIND_LO  = 4 * VEC_W;

    // configuration register map
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;
    localparam logic [2:0] REG_FIRST_NODE   = 3'd0;
    localparam logic [2:0] REG_LAST_NODE    = 3'd1;
    localparam logic [2:0] REG_REMAP_ENABLE = 3'd2;
    localparam logic [2:0] REG_CURRENT_LOW  = 3'd3;
    localparam logic [2:0] REG_CURRENT_HIGH = 3'd4;
    localparam logic [2:0] REG_WATER_CODE   = 3'd5;

    typedef struct packed {
        logic [INDEX_W-1:0]       first_node;
        logic [INDEX_W-1:0]       last_node;
        logic                     remap_enable;
        logic signed [CODE_W-1:0] current_low;
        logic signed [CODE_W-1:0] current_high;
        logic signed [CODE_W-1:0] water_code;
    } t_cfg;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NODE,
        ST_PLANE,
        ST_KIND,
        ST_MUL_Y,
        ST_MUL_Z,
        ST_ACC,
        ST_CMP,
        ST_DONE
    } t_state;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_NODE_RD,
        OP_PLANE_RD,
        OP_STEP_AXIAL,
        OP_MUL_X,
        OP_MUL_Y,
        OP_MUL_Z,
        OP_ACC,
        OP_STEP_GENERAL,
        OP_FIN_LEAF,
        OP_FIN_BAD,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic in_query;
        logic num_neg;
        logic node_bad;
        logic plane_bad;
        logic kind_axial;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### hdl/bsp_point_contents.sv
// ----------------------------------------------------------------------------
// bsp_point_contents - bsp clip-node tree point contents engine
// Input stream: tuser carries the command (query, write node, write plane),
// tdata the index, point or plane normal, offset, kind, plane ref, children.
// Write items fill the node and plane memories and are answered with a zero
// result; a query walks the tree from its start node and returns the leaf
// contents code, a bad node flag and the number of nodes visited.
// Sequence: a write goes from accept to the result state, then to the output
// register. A query runs node read, plane read and kind test per axial node;
// a general node adds three passes through one shared 32x32 multiplier and a
// 66 bit accumulate and compare. The walk ends with leaf test and result.
// One item is walked at a time; the next beat is taken once the result has
// moved to the output register, so a result waiting on a stalled receiver
// does not hold off the next item, but a second finished result waits until
// the first has gone.
// Reset clears the controller, the output valid and the configuration registers; the node
// and plane memories keep no reset value and must be written before use.
// The user must write the configuration over apb only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_point_contents #(
    parameter int NODE_COUNT  = bsp_pc_pkg::NODE_COUNT_DEF,
    parameter int PLANE_COUNT = bsp_pc_pkg::PLANE_COUNT_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // apb configuration port
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire [bsp_pc_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire [bsp_pc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bsp_pc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                  pready,
    // input stream
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // index[9:0], vec_x[41:10], vec_y[73:42], vec_z[105:74],
    // plane_dist[137:106], plane_kind[140:138], plane_ref[150:141],
    // child_front[161:151], child_back[172:162], zero pad[175:173]
    input  wire [bsp_pc_pkg::S_TDATA_W-1:0]       s_axis_tdata,
    // cmd[1:0]
    input  wire [bsp_pc_pkg::S_TUSER_W-1:0]       s_axis_tuser,
    // result stream
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // contents[4:0], steps_taken[15:5]
    output logic [bsp_pc_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // bad_node[0]
    output logic [bsp_pc_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

    bsp_pc_pkg::t_cfg                            cfg;
    bsp_pc_pkg::t_dp_cmd                         dp_cmd;
    bsp_pc_pkg::t_dp_status                      dp_status;
    logic signed [bsp_pc_pkg::CODE_W-1:0]        out_contents;
    logic                                        out_bad;
    logic [bsp_pc_pkg::STEPS_W-1:0]              out_steps;

    bsp_pc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bsp_pc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd)
    );

    bsp_pc_dp #(
        .NODE_COUNT  (NODE_COUNT),
        .PLANE_COUNT (PLANE_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .i_cfg            (cfg),
        .i_in_cmd         (s_axis_tuser[1:0]),
        .i_in_index       (s_axis_tdata[9:0]),
        .i_in_vec_x       ($signed(s_axis_tdata[41:10])),
        .i_in_vec_y       ($signed(s_axis_tdata[73:42])),
        .i_in_vec_z       ($signed(s_axis_tdata[105:74])),
        .i_in_plane_dist  ($signed(s_axis_tdata[137:106])),
        .i_in_plane_kind  (s_axis_tdata[140:138]),
        .i_in_plane_ref   (s_axis_tdata[150:141]),
        .i_in_child_front ($signed(s_axis_tdata[161:151])),
        .i_in_child_back  ($signed(s_axis_tdata[172:162])),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_contents       (out_contents),
        .o_bad_node       (out_bad),
        .o_steps_taken    (out_steps)
    );

    // result packing
    assign m_axis_tdata = {out_steps, out_contents};
    assign m_axis_tuser = out_bad;

endmodule

`default_nettype wire

### hdl/bsp_pc_ram.sv
// ----------------------------------------------------------------------------
// bsp_pc_ram - generic single write port, single read port ram
// read data is registered and held while the read enable is low
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_pc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/bsp_pc_regs.sv
// ----------------------------------------------------------------------------
// bsp_pc_regs - configuration registers behind a simple apb port
// hull node window and contents remap settings, one register per word
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_pc_regs (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [bsp_pc_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire [bsp_pc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [bsp_pc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                 pready,
    output bsp_pc_pkg::t_cfg                     o_cfg
);

    bsp_pc_pkg::t_cfg r_cfg;
    logic [2:0]       reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[bsp_pc_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_node   <= 10'd0;
            r_cfg.last_node    <= 10'd1023;
            r_cfg.remap_enable <= 1'b0;
            r_cfg.current_low  <= -5'sd14;
            r_cfg.current_high <= -5'sd9;
            r_cfg.water_code   <= -5'sd3;
        end else if (wr_en) begin
            case (reg_idx)
                bsp_pc_pkg::REG_FIRST_NODE: begin
                    r_cfg.first_node <= pwdata[bsp_pc_pkg::INDEX_W-1:0];
                end
                bsp_pc_pkg::REG_LAST_NODE: begin
                    r_cfg.last_node <= pwdata[bsp_pc_pkg::INDEX_W-1:0];
                end
                bsp_pc_pkg::REG_REMAP_ENABLE: begin
                    r_cfg.remap_enable <= pwdata[0];
                end
                bsp_pc_pkg::REG_CURRENT_LOW: begin
                    r_cfg.current_low <= $signed(pwdata[bsp_pc_pkg::CODE_W-1:0]);
                end
                bsp_pc_pkg::REG_CURRENT_HIGH: begin
                    r_cfg.current_high <= $signed(pwdata[bsp_pc_pkg::CODE_W-1:0]);
                end
                bsp_pc_pkg::REG_WATER_CODE: begin
                    r_cfg.water_code <= $signed(pwdata[bsp_pc_pkg::CODE_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        case (reg_idx)
            bsp_pc_pkg::REG_FIRST_NODE:   prdata = 32'(r_cfg.first_node);
            bsp_pc_pkg::REG_LAST_NODE:    prdata = 32'(r_cfg.last_node);
            bsp_pc_pkg::REG_REMAP_ENABLE: prdata = 32'(r_cfg.remap_enable);
            bsp_pc_pkg::REG_CURRENT_LOW:  prdata = 32'(unsigned'(r_cfg.current_low));
            bsp_pc_pkg::REG_CURRENT_HIGH: prdata = 32'(unsigned'(r_cfg.current_high));
            bsp_pc_pkg::REG_WATER_CODE:   prdata = 32'(unsigned'(r_cfg.water_code));
            default:                      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### hdl/bsp_pc_ctrl.sv
// ----------------------------------------------------------------------------
// bsp_pc_ctrl - tree walk sequencer
// steps each query through node read, plane read and the distance test,
// and hands writes straight to the result stage
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_pc_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_s_valid,
    output logic                      o_s_ready,
    input  bsp_pc_pkg::t_dp_status    i_status,
    output bsp_pc_pkg::t_dp_cmd       o_cmd
);

    bsp_pc_pkg::t_state r_state;
    bsp_pc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsp_pc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state   = r_state;
        o_cmd.op  = bsp_pc_pkg::OP_NONE;
        o_s_ready = 1'b0;
        case (r_state)
            bsp_pc_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.op = bsp_pc_pkg::OP_LOAD;
                    n_state  = i_status.in_query ? bsp_pc_pkg::ST_NODE
                                                 : bsp_pc_pkg::ST_DONE;
                end
            end
            // leaf reached, node out of window or walk too long
            bsp_pc_pkg::ST_NODE: begin
                if (i_status.num_neg) begin
                    o_cmd.op = bsp_pc_pkg::OP_FIN_LEAF;
                    n_state  = bsp_pc_pkg::ST_DONE;
                end else if (i_status.node_bad) begin
                    o_cmd.op = bsp_pc_pkg::OP_FIN_BAD;
                    n_state  = bsp_pc_pkg::ST_DONE;
                end else begin
                    o_cmd.op = bsp_pc_pkg::OP_NODE_RD;
                    n_state  = bsp_pc_pkg::ST_PLANE;
                end
            end
            // node word is in, fetch its plane
            bsp_pc_pkg::ST_PLANE: begin
                if (i_status.plane_bad) begin
                    o_cmd.op = bsp_pc_pkg::OP_FIN_BAD;
                    n_state  = bsp_pc_pkg::ST_DONE;
                end else begin
                    o_cmd.op = bsp_pc_pkg::OP_PLANE_RD;
                    n_state  = bsp_pc_pkg::ST_KIND;
                end
            end
            // plane word is in, axial test now or start the dot product
            bsp_pc_pkg::ST_KIND: begin
                if (i_status.kind_axial) begin
                    o_cmd.op = bsp_pc_pkg::OP_STEP_AXIAL;
                    n_state  = bsp_pc_pkg::ST_NODE;
                end else begin
                    o_cmd.op = bsp_pc_pkg::OP_MUL_X;
                    n_state  = bsp_pc_pkg::ST_MUL_Y;
                end
            end
            bsp_pc_pkg::ST_MUL_Y: begin
                o_cmd.op = bsp_pc_pkg::OP_MUL_Y;
                n_state  = bsp_pc_pkg::ST_MUL_Z;
            end
            bsp_pc_pkg::ST_MUL_Z: begin
                o_cmd.op = bsp_pc_pkg::OP_MUL_Z;
                n_state  = bsp_pc_pkg::ST_ACC;
            end
            bsp_pc_pkg::ST_ACC: begin
                o_cmd.op = bsp_pc_pkg::OP_ACC;
                n_state  = bsp_pc_pkg::ST_CMP;
            end
            bsp_pc_pkg::ST_CMP: begin
                o_cmd.op = bsp_pc_pkg::OP_STEP_GENERAL;
                n_state  = bsp_pc_pkg::ST_NODE;
            end
            // wait for room in the output register
            bsp_pc_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.op = bsp_pc_pkg::OP_EMIT;
                    n_state  = bsp_pc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bsp_pc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/bsp_pc_dp.sv
// ----------------------------------------------------------------------------
// bsp_pc_dp - tree walk datapath
// node and plane memories, point and walk registers, one shared 32x32
// multiplier with a wide accumulator, result stage and output register
// ----------------------------------------------------------------------------
`default_nettype none

module bsp_pc_dp #(
    parameter int NODE_COUNT  = bsp_pc_pkg::NODE_COUNT_DEF,
    parameter int PLANE_COUNT = bsp_pc_pkg::PLANE_COUNT_DEF
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  bsp_pc_pkg::t_dp_cmd                       i_cmd,
    output bsp_pc_pkg::t_dp_status                    o_status,
    input  bsp_pc_pkg::t_cfg                          i_cfg,
    // input item fields
    input  wire [bsp_pc_pkg::CMD_W-1:0]               i_in_cmd,
    input  wire [bsp_pc_pkg::INDEX_W-1:0]             i_in_index,
    input  wire signed [bsp_pc_pkg::VEC_W-1:0]        i_in_vec_x,
    input  wire signed [bsp_pc_pkg::VEC_W-1:0]        i_in_vec_y,
    input  wire signed [bsp_pc_pkg::VEC_W-1:0]        i_in_vec_z,
    input  wire signed [bsp_pc_pkg::VEC_W-1:0]        i_in_plane_dist,
    input  wire [bsp_pc_pkg::KIND_W-1:0]              i_in_plane_kind,
    input  wire [bsp_pc_pkg::REF_W-1:0]               i_in_plane_ref,
    input  wire signed [bsp_pc_pkg::CHILD_W-1:0]      i_in_child_front,
    input  wire signed [bsp_pc_pkg::CHILD_W-1:0]      i_in_child_back,
    // result item
    output logic                                      o_out_valid,
    input  wire                                       i_out_ready,
    output logic signed [bsp_pc_pkg::CODE_W-1:0]      o_contents,
    output logic                                      o_bad_node,
    output logic [bsp_pc_pkg::STEPS_W-1:0]            o_steps_taken
);

    localparam int NADDR_W = $clog2(NODE_COUNT);
    localparam int PADDR_W = $clog2(PLANE_COUNT);
    localparam int STEP_W  = $clog2(NODE_COUNT + 1);

    localparam int VW = bsp_pc_pkg::VEC_W;
    localparam int CW = bsp_pc_pkg::CHILD_W;

    // walk state
    logic signed [CW-1:0]                     r_num;
    logic [STEP_W-1:0]                        r_steps;
    logic signed [VW-1:0]                     r_px;
    logic signed [VW-1:0]                     r_py;
    logic signed [VW-1:0]                     r_pz;
    logic signed [CW-1:0]                     r_front;
    logic signed [CW-1:0]                     r_back;
    logic signed [bsp_pc_pkg::PROD_W-1:0]     r_prod;
    logic signed [bsp_pc_pkg::ACC_W-1:0]      r_acc;

    // result stage and output register
    logic signed [bsp_pc_pkg::CODE_W-1:0]     r_res_contents;
    logic                                     r_res_bad;
    logic                                     r_out_valid;
    logic signed [bsp_pc_pkg::CODE_W-1:0]     r_out_contents;
    logic                                     r_out_bad;
    logic [bsp_pc_pkg::STEPS_W-1:0]           r_out_steps;

    // memory ports
    logic                                     node_we;
    logic [NADDR_W-1:0]                       node_waddr;
    logic [bsp_pc_pkg::NODE_W-1:0]            node_wdata;
    logic                                     node_re;
    logic [NADDR_W-1:0]                       node_raddr;
    logic [bsp_pc_pkg::NODE_W-1:0]            node_rdata;
    logic                                     plane_we;
    logic [PADDR_W-1:0]                       plane_waddr;
    logic [bsp_pc_pkg::PLANE_W-1:0]           plane_wdata;
    logic                                     plane_re;
    logic [PADDR_W-1:0]                       plane_raddr;
    logic [bsp_pc_pkg::PLANE_W-1:0]           plane_rdata;

    // decoded words
    logic [31:0]                              in_index_ext;
    logic [31:0]                              num_ext;
    logic [31:0]                              ref_ext;
    logic [31:0]                              steps_ext;
    logic [bsp_pc_pkg::REF_W-1:0]             node_ref;
    logic signed [VW-1:0]                     pl_nx;
    logic signed [VW-1:0]                     pl_ny;
    logic signed [VW-1:0]                     pl_nz;
    logic signed [VW-1:0]                     pl_off;
    logic [bsp_pc_pkg::KIND_W-1:0]            pl_kind;
    logic signed [VW-1:0]                     axis_coord;
    logic                                     axial_neg;
    logic signed [bsp_pc_pkg::ACC_W-1:0]      off_scaled;
    logic                                     general_neg;
    logic signed [CW-1:0]                     cur_low_ext;
    logic signed [CW-1:0]                     cur_high_ext;
    logic signed [CW-1:0]                     leaf_mapped;
    logic signed [CW-1:0]                     leaf_sat;
    logic                                     load;
    logic                                     emit;

    assign load = (i_cmd.op == bsp_pc_pkg::OP_LOAD);
    assign emit = (i_cmd.op == bsp_pc_pkg::OP_EMIT);

    // index extension for range checks and addressing
    assign in_index_ext = 32'(i_in_index);
    assign num_ext      = 32'(unsigned'(r_num[bsp_pc_pkg::INDEX_W-1:0]));
    assign node_ref     = node_rdata[bsp_pc_pkg::NODE_REF_LO +: bsp_pc_pkg::REF_W];
    assign ref_ext      = 32'(node_ref);
    assign steps_ext    = 32'(r_steps);

    // table writes come straight from the accepted beat
    assign node_we     = load && (i_in_cmd == bsp_pc_pkg::CMD_NODE)
                         && (in_index_ext < 32'(NODE_COUNT));
    assign node_waddr  = in_index_ext[NADDR_W-1:0];
    assign node_wdata  = {i_in_child_back, i_in_child_front, i_in_plane_ref};
    assign plane_we    = load && (i_in_cmd == bsp_pc_pkg::CMD_PLANE)
                         && (in_index_ext < 32'(PLANE_COUNT));
    assign plane_waddr = in_index_ext[PADDR_W-1:0];
    assign plane_wdata = {i_in_plane_kind, i_in_plane_dist, i_in_vec_z,
                          i_in_vec_y, i_in_vec_x};

    // table reads during the walk
    assign node_re     = (i_cmd.op == bsp_pc_pkg::OP_NODE_RD);
    assign node_raddr  = num_ext[NADDR_W-1:0];
    assign plane_re    = (i_cmd.op == bsp_pc_pkg::OP_PLANE_RD);
    assign plane_raddr = ref_ext[PADDR_W-1:0];

    bsp_pc_ram #(
        .WIDTH (bsp_pc_pkg::NODE_W),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_re    (node_re),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    bsp_pc_ram #(
        .WIDTH (bsp_pc_pkg::PLANE_W),
        .DEPTH (PLANE_COUNT)
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (plane_we),
        .i_waddr (plane_waddr),
        .i_wdata (plane_wdata),
        .i_re    (plane_re),
        .i_raddr (plane_raddr),
        .o_rdata (plane_rdata)
    );

    // plane word fields
    assign pl_nx   = $signed(plane_rdata[bsp_pc_pkg::PL_NX_LO +: VW]);
    assign pl_ny   = $signed(plane_rdata[bsp_pc_pkg::PL_NY_LO +: VW]);
    assign pl_nz   = $signed(plane_rdata[bsp_pc_pkg::PL_NZ_LO +: VW]);
    assign pl_off  = $signed(plane_rdata[bsp_pc_pkg::PL_OFF_LO +: VW]);
    assign pl_kind = plane_rdata[bsp_pc_pkg::PL_KIND_LO +: bsp_pc_pkg::KIND_W];

    // axial distance sign: coordinate minus offset
    always_comb begin
        case (pl_kind)
            bsp_pc_pkg::KIND_AXIS_X: axis_coord = r_px;
            bsp_pc_pkg::KIND_AXIS_Y: axis_coord = r_py;
            default:                 axis_coord = r_pz;
        endcase
    end
    assign axial_neg = (axis_coord < pl_off);

    // general distance sign: exact dot product against offset in 32.32
    assign off_scaled  = {{(bsp_pc_pkg::ACC_W - VW - 16){pl_off[VW-1]}}, pl_off, 16'd0};
    assign general_neg = (r_acc < off_scaled);

    // leaf code remap and saturation
    assign cur_low_ext  = {{(CW - bsp_pc_pkg::CODE_W){i_cfg.current_low[4]}},
                           i_cfg.current_low};
    assign cur_high_ext = {{(CW - bsp_pc_pkg::CODE_W){i_cfg.current_high[4]}},
                           i_cfg.current_high};
    always_comb begin
        leaf_mapped = r_num;
        if (i_cfg.remap_enable && (r_num >= cur_low_ext) && (r_num <= cur_high_ext)) begin
            leaf_mapped = {{(CW - bsp_pc_pkg::CODE_W){i_cfg.water_code[4]}},
                           i_cfg.water_code};
        end
        leaf_sat = leaf_mapped;
        if (leaf_mapped < -11'sd16) begin
            leaf_sat = -11'sd16;
        end
    end

    // status back to the controller
    assign o_status.in_query   = (i_in_cmd == bsp_pc_pkg::CMD_QUERY);
    assign o_status.num_neg    = r_num[CW-1];
    assign o_status.node_bad   = (r_num[bsp_pc_pkg::INDEX_W-1:0] < i_cfg.first_node)
                                 || (r_num[bsp_pc_pkg::INDEX_W-1:0] > i_cfg.last_node)
                                 || (num_ext >= 32'(NODE_COUNT))
                                 || (steps_ext >= 32'(NODE_COUNT));
    assign o_status.plane_bad  = (ref_ext >= 32'(PLANE_COUNT));
    assign o_status.kind_axial = (pl_kind < bsp_pc_pkg::KIND_GENERAL);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // walk registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bsp_pc_pkg::OP_LOAD: begin
                r_num   <= $signed({1'b0, i_in_index});
                r_steps <= '0;
                r_px    <= i_in_vec_x;
                r_py    <= i_in_vec_y;
                r_pz    <= i_in_vec_z;
                // acknowledgement result for writes
                r_res_contents <= '0;
                r_res_bad      <= 1'b0;
            end
            bsp_pc_pkg::OP_PLANE_RD: begin
                r_front <= $signed(node_rdata[bsp_pc_pkg::NODE_FR_LO +: CW]);
                r_back  <= $signed(node_rdata[bsp_pc_pkg::NODE_BK_LO +: CW]);
                r_steps <= r_steps + {{(STEP_W-1){1'b0}}, 1'b1};
            end
            bsp_pc_pkg::OP_STEP_AXIAL: begin
                r_num <= axial_neg ? r_back : r_front;
            end
            bsp_pc_pkg::OP_MUL_X: begin
                r_prod <= pl_nx * r_px;
            end
            bsp_pc_pkg::OP_MUL_Y: begin
                r_acc  <= {{(bsp_pc_pkg::ACC_W - bsp_pc_pkg::PROD_W){r_prod[63]}}, r_prod};
                r_prod <= pl_ny * r_py;
            end
            bsp_pc_pkg::OP_MUL_Z: begin
                r_acc  <= r_acc + {{(bsp_pc_pkg::ACC_W - bsp_pc_pkg::PROD_W){r_prod[63]}},
                                   r_prod};
                r_prod <= pl_nz * r_pz;
            end
            bsp_pc_pkg::OP_ACC: begin
                r_acc <= r_acc + {{(bsp_pc_pkg::ACC_W - bsp_pc_pkg::PROD_W){r_prod[63]}},
                                  r_prod};
            end
            bsp_pc_pkg::OP_STEP_GENERAL: begin
                r_num <= general_neg ? r_back : r_front;
            end
            bsp_pc_pkg::OP_FIN_LEAF: begin
                r_res_contents <= leaf_sat[bsp_pc_pkg::CODE_W-1:0];
                r_res_bad      <= 1'b0;
            end
            bsp_pc_pkg::OP_FIN_BAD: begin
                r_res_contents <= '0;
                r_res_bad      <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_contents <= r_res_contents;
            r_out_bad      <= r_res_bad;
            r_out_steps    <= steps_ext[bsp_pc_pkg::STEPS_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_contents    = r_out_contents;
    assign o_bad_node    = r_out_bad;
    assign o_steps_taken = r_out_steps;

endmodule

`default_nettype wire
